// ===== rtl/core/swtb_pkg.sv =====
// Shared command codes, state encoding and reset constants for the stopwatch timer bank.
`timescale 1ns / 1ps
`default_nettype none

package swtb_pkg;

  // Command codes carried on the cmd field. Code 7 is unused and ignored.
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LAP    = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_RESUME = 3'd5,
    CMD_STOP   = 3'd6
  } cmd_t;

  // The one code on the cmd field that has no command behind it.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Sequencer states: waiting for an item, or finishing a timer command.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } seq_state_t;

  localparam int          MPM_W     = 10;
  localparam int          TIME_W    = 32;
  localparam logic [9:0]  MPM_RESET = 10'd1000;

endpackage

`default_nettype wire

// ===== rtl/core/swtb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module swtb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stopwatch_timer_bank.sv =====
// Top level of the stopwatch timer bank: clocks, timer state memories and command sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     cmd, timer_index, use_milli
// result    out        out_valid / out_stall   elapsed
// config    in         cfg_valid / cfg_ready   micros_per_milli
//
// A tick, or the unused command code, is taken in ST_IDLE and the block is ready again at once.
// A timer command has its memories read at its transfer in ST_IDLE; ST_EXEC then
// computes, writes back and loads any result. A get or lap stays in ST_EXEC, with
// the input stalled, while the result register is still full and stalled.
// Reset is synchronous and active high: it clears the clocks, stamp valid bits and paused
// flags, sets every stopped flag and returns micros_per_milli to 1000.

module stopwatch_timer_bank
  import swtb_pkg::*;
#(
  parameter int TIMER_COUNT = 16
) (
  input  wire               clk,
  input  wire               rst,
  // Command and tick items.
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [2:0]        cmd,
  input  wire  [3:0]        timer_index,
  input  wire               use_milli,
  // Results of get and lap.
  output logic              out_valid,
  input  wire               out_stall,
  output logic [31:0]       elapsed,
  // Configuration write channel.
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [9:0]        micros_per_milli
);

  // Each timer has two entries in each memory, one per side; the side is the low address bit.
  localparam int TIDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int ENTRIES = 2 * TIMER_COUNT;
  localparam int ADDR_W = $clog2(ENTRIES);

  // Control state.
  seq_state_t              state;
  seq_state_t              state_next;
  logic [MPM_W-1:0]        mpm_limit;
  logic [TIME_W-1:0]       micro_clock;
  logic [TIME_W-1:0]       milli_clock;
  logic [MPM_W-1:0]        sub_milli_count;
  logic [MPM_W-1:0]        sub_milli_count_next;
  logic [ENTRIES-1:0]      stamp_valid;
  logic [ENTRIES-1:0]      paused;
  logic [TIMER_COUNT-1:0]  stopped;

  // The command being finished.
  cmd_t                    cmd_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [TIDX_W-1:0]       tsel_q;
  logic                    milli_q;
  logic                    in_range_q;

  // Handshake and datapath signals.
  logic                    in_xfer;
  logic                    is_tick;
  logic                    is_timer_cmd;
  logic                    in_range;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    need_result;
  logic                    blocked;
  logic                    exec_go;
  logic                    out_load;
  logic [TIME_W-1:0]       stamp_rdata;
  logic [TIME_W-1:0]       held_rdata;
  logic [TIME_W-1:0]       now;
  logic [TIME_W-1:0]       stamp_cur;
  logic [TIME_W-1:0]       diff;
  logic [TIME_W-1:0]       resume_stamp;
  logic [TIME_W-1:0]       result;
  logic                    live;
  logic                    cur_paused;
  logic                    stamp_we;
  logic [TIME_W-1:0]       stamp_wdata;
  logic                    held_we;
  logic                    set_paused;
  logic                    clr_paused;
  logic                    set_stopped;
  logic                    clr_stopped;

  assign cfg_ready = 1'b1;

  assign in_xfer  = in_valid && !in_stall;
  assign in_range = (32'(timer_index) < TIMER_COUNT);
  assign rd_addr  = ADDR_W'({TIDX_W'(timer_index), use_milli});

  // Ticks and the unused code finish on the cycle they are taken.
  always_comb begin
    is_tick      = 1'b0;
    is_timer_cmd = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_TICK: begin
        is_tick = 1'b1;
      end
      CMD_START, CMD_GET, CMD_LAP, CMD_PAUSE, CMD_RESUME, CMD_STOP: begin
        is_timer_cmd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The millisecond clock advances when the sub-count reaches the limit; a limit of zero
  // therefore advances it on every tick.
  assign sub_milli_count_next = sub_milli_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mpm_limit       <= MPM_RESET;
      micro_clock     <= '0;
      milli_clock     <= '0;
      sub_milli_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mpm_limit <= micros_per_milli;
      end
      if (in_xfer && is_tick) begin
        micro_clock <= micro_clock + 1'b1;
        if (sub_milli_count_next >= mpm_limit) begin
          sub_milli_count <= '0;
          milli_clock     <= milli_clock + 1'b1;
        end else begin
          sub_milli_count <= sub_milli_count_next;
        end
      end
    end
  end

  // Capture the command while its memory read is under way.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q      <= cmd_t'(cmd);
      addr_q     <= rd_addr;
      tsel_q     <= TIDX_W'(timer_index);
      milli_q    <= use_milli;
      in_range_q <= in_range;
    end
  end

  // Stamps per timer and side. Entries never written read as zero through stamp_valid.
  swtb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (addr_q),
    .wdata (stamp_wdata),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (stamp_rdata)
  );

  // Held elapsed values per timer and side. A held value is only read while its side is
  // paused, and pausing always writes it first.
  swtb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (ENTRIES)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (addr_q),
    .wdata (diff),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (held_rdata)
  );

  // Elapsed-time arithmetic for the captured command.
  assign now          = milli_q ? milli_clock : micro_clock;
  assign stamp_cur    = stamp_valid[addr_q] ? stamp_rdata : '0;
  assign diff         = now - stamp_cur;
  assign resume_stamp = now - held_rdata;
  assign live         = in_range_q && !stopped[tsel_q];
  assign cur_paused   = paused[addr_q];
  assign result       = !live ? '0 : (cur_paused ? held_rdata : diff);
  assign need_result  = (cmd_q == CMD_GET) || (cmd_q == CMD_LAP);

  // A get or lap cannot finish while the previous result is still waiting.
  assign blocked = need_result && out_valid && out_stall;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && is_timer_cmd) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!blocked) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output and write-back decisions.
  always_comb begin
    in_stall    = 1'b1;
    exec_go     = 1'b0;
    stamp_we    = 1'b0;
    stamp_wdata = now;
    held_we     = 1'b0;
    set_paused  = 1'b0;
    clr_paused  = 1'b0;
    set_stopped = 1'b0;
    clr_stopped = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_EXEC: begin
        exec_go = !blocked;
        if (exec_go && in_range_q) begin
          unique case (cmd_q)
            CMD_START: begin
              stamp_we    = 1'b1;
              clr_stopped = 1'b1;
            end
            CMD_LAP: begin
              stamp_we = live;
            end
            CMD_PAUSE: begin
              held_we    = live && !cur_paused;
              set_paused = live && !cur_paused;
            end
            CMD_RESUME: begin
              stamp_we    = live && cur_paused;
              stamp_wdata = resume_stamp;
              clr_paused  = live && cur_paused;
            end
            CMD_STOP: begin
              set_stopped = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign out_load = exec_go && need_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stamp_valid <= '0;
      paused      <= '0;
      stopped     <= '1;
    end else begin
      state <= state_next;
      if (stamp_we) begin
        stamp_valid[addr_q] <= 1'b1;
      end
      if (set_paused) begin
        paused[addr_q] <= 1'b1;
      end else if (clr_paused) begin
        paused[addr_q] <= 1'b0;
      end
      if (set_stopped) begin
        stopped[tsel_q] <= 1'b1;
      end else if (clr_stopped) begin
        stopped[tsel_q] <= 1'b0;
      end
    end
  end

  // Result register: holds one get or lap result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      elapsed <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/swtb_checker.sv =====
// Port-level assertions for the stopwatch timer bank, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module swtb_checker
  import swtb_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire [2:0]  cmd,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] elapsed
);

  // A tick or the unused code leaves the block ready in the very next cycle.
  a_tick_no_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (cmd == CMD_TICK || cmd == CMD_UNUSED)) |=> !in_stall)
    else $error("block stalled after a tick transfer");

  // A timer command keeps the input stalled while it is written back.
  a_cmd_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd != CMD_TICK && cmd != CMD_UNUSED) |=> in_stall)
    else $error("input not stalled during a timer command");

  // A get or lap taken with an empty result register shows its result once ST_EXEC loads the result register.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid && (cmd == CMD_GET || cmd == CMD_LAP))
      |-> ##2 out_valid)
    else $error("get or lap result missing");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(elapsed)))
    else $error("stalled result changed or dropped");

endmodule

bind stopwatch_timer_bank swtb_checker u_swtb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .elapsed   (elapsed)
);

`default_nettype wire
